/* rtl/caes_pkg.sv */
`default_nettype none
package caes_pkg;

   localparam int unsigned CARRIER_W = 32;
   localparam int unsigned OUT_W     = 19;
   localparam int unsigned FIELDS    = 10;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int          NEG_CHANNELS = 4;

   // quarter-wave polynomial coefficients, Q30
   localparam logic [30:0] C1 = 31'd1686629713;
   localparam logic [30:0] C3 = 31'd693598668;
   localparam logic [30:0] C5 = 31'd85569306;
   localparam logic [30:0] C7 = 31'd5026995;
   localparam logic [30:0] C9 = 31'd172272;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic [1:0] MODE_MIN  = 2'd0;
   localparam logic [1:0] MODE_MAX  = 2'd1;
   localparam logic [1:0] MODE_MEAN = 2'd2;
   localparam logic [1:0] MODE_USER = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_POS_CARRIER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEG_CARRIER_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEG_CARRIER_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEG_CARRIER_C = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEG_CARRIER_D = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MODE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_USER_CARRIER  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_START_OFFSET  = 3'd7;

   typedef struct packed {
      logic [CARRIER_W-1:0] pos_carrier;
      logic [3:0][CARRIER_W-1:0] neg_carrier;
      logic [1:0]           out_mode;
      logic [CARRIER_W-1:0] user_carrier;
      logic [CARRIER_W-1:0] start_offset;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

endpackage
`default_nettype wire

/* rtl/carrier_aligned_envelope_subtractor.sv */
// carrier aligned envelope subtractor
// input channel req_*: one transfer carries a complex sample of the positive
// channel and of each negative channel; req_stall is high while the two-entry
// queue between the front and the back end is full
// result channel rsp_*: one transfer per input item, out_re/out_im, 19 bit
// configuration port csr_*: write-only, index 0..7, taken in any cycle
// the front end picks the output carrier and stamps the sample time; the back
// end rotates each of the NEG_CHANNELS+1 samples, using one shared 32x32
// multiplier for the phase and the quarter-wave sine polynomial, sine then cosine
// a rotated channel passes through the phase, the phase product, the sine
// and cosine polynomials, the two rotation products and the accumulate; a
// channel whose carrier matches the output carrier skips to the accumulate
// after the phase product; an item is popped only once the last is finished
// the finished result sits in an output register; the back end can start the
// next item while it waits, so a stalled receiver only holds the pipeline
// once the next result is also done
// reset clears the queue, the sample counter and the result valid, and loads
// out_mode with mean and all other registers with zero
`default_nettype none
module carrier_aligned_envelope_subtractor
   import caes_pkg::*;
#(
   parameter int SAMPLE_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_pos_re,
   input  wire logic signed [SAMPLE_BITS-1:0] req_pos_im,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_re_a,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_im_a,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_re_b,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_im_b,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_re_c,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_im_c,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_re_d,
   input  wire logic signed [SAMPLE_BITS-1:0] req_neg_im_d,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [OUT_W-1:0]            rsp_out_re,
   output logic signed [OUT_W-1:0]            rsp_out_im,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CARRIER_W-1:0]          csr_wdata
);

   localparam int ENTRY_W = 2 * CARRIER_W + FIELDS * SAMPLE_BITS;

   cfg_type                            cfg_ff;
   logic [FIELDS-1:0][SAMPLE_BITS-1:0] samples;
   logic                               push;
   logic                               pop;
   logic [ENTRY_W-1:0]                 wr_entry;
   logic [ENTRY_W-1:0]                 rd_entry;
   queue_ctl_type                      qstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pos_carrier: '0, neg_carrier: '0, out_mode: MODE_MEAN,
                     user_carrier: '0, start_offset: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POS_CARRIER:   cfg_ff.pos_carrier    <= csr_wdata;
            REG_NEG_CARRIER_A: cfg_ff.neg_carrier[0] <= csr_wdata;
            REG_NEG_CARRIER_B: cfg_ff.neg_carrier[1] <= csr_wdata;
            REG_NEG_CARRIER_C: cfg_ff.neg_carrier[2] <= csr_wdata;
            REG_NEG_CARRIER_D: cfg_ff.neg_carrier[3] <= csr_wdata;
            REG_OUT_MODE:      cfg_ff.out_mode       <= csr_wdata[1:0];
            REG_USER_CARRIER:  cfg_ff.user_carrier   <= csr_wdata;
            REG_START_OFFSET:  cfg_ff.start_offset   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign samples = {req_neg_im_d, req_neg_re_d, req_neg_im_c, req_neg_re_c,
                     req_neg_im_b, req_neg_re_b, req_neg_im_a, req_neg_re_a,
                     req_pos_im, req_pos_re};

   caes_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .samples   (samples),
      .queue_full(qstat.full),
      .req_stall (req_stall),
      .push      (push),
      .entry     (wr_entry)
   );

   caes_queue #(
      .ENTRY_W(ENTRY_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .wr_entry(wr_entry),
      .rd_entry(rd_entry),
      .status  (qstat)
   );

   caes_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .entry     (rd_entry),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_re(rsp_out_re),
      .rsp_out_im(rsp_out_im)
   );

endmodule
`default_nettype wire

/* rtl/caes_front.sv */
`default_nettype none
module caes_front
   import caes_pkg::*;
#(
   parameter int SAMPLE_BITS  = 16,
   parameter int ENTRY_W      = 2 * CARRIER_W + FIELDS * SAMPLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cfg_type                             cfg,
   input  wire logic                                req_valid,
   input  wire logic [FIELDS-1:0][SAMPLE_BITS-1:0]  samples,
   input  wire logic                                queue_full,
   output logic                                     req_stall,
   output logic                                     push,
   output logic [ENTRY_W-1:0]                       entry
);

   localparam int SUM_W = CARRIER_W + 3;

   logic [CARRIER_W-1:0]        sample_index_ff;
   logic signed [CARRIER_W-1:0] lo, hi;
   logic signed [SUM_W-1:0]     sum, mean;
   logic [CARRIER_W-1:0]        out_carrier;
   logic [CARRIER_W-1:0]        tm;

   // output carrier choice
   always_comb begin
      lo  = $signed(cfg.neg_carrier[0]);
      hi  = $signed(cfg.neg_carrier[0]);
      sum = '0;
      for (int i = 0; i < NEG_CHANNELS; i++) begin
         if ($signed(cfg.neg_carrier[i]) < lo) begin
            lo = $signed(cfg.neg_carrier[i]);
         end
         if ($signed(cfg.neg_carrier[i]) > hi) begin
            hi = $signed(cfg.neg_carrier[i]);
         end
         sum = sum + SUM_W'($signed(cfg.neg_carrier[i]));
      end
      mean = sum / NEG_CHANNELS;
      case (cfg.out_mode)
         MODE_MIN:  out_carrier = lo;
         MODE_MAX:  out_carrier = hi;
         MODE_MEAN: out_carrier = mean[CARRIER_W-1:0];
         default:   out_carrier = cfg.user_carrier;
      endcase
   end

   assign tm        = sample_index_ff + cfg.start_offset;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign entry     = {out_carrier, tm, samples};

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
      end else if (push) begin
         sample_index_ff <= sample_index_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

/* rtl/caes_queue.sv */
`default_nettype none
module caes_queue
   import caes_pkg::*;
#(
   parameter int ENTRY_W = 224
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic               pop,
   input  wire logic [ENTRY_W-1:0] wr_entry,
   output logic [ENTRY_W-1:0]      rd_entry,
   output queue_ctl_type           status
);

   logic [1:0][ENTRY_W-1:0] slot_ff;
   logic                    wr_ptr_ff;
   logic                    rd_ptr_ff;
   logic [1:0]              count_ff;

   assign rd_entry      = slot_ff[rd_ptr_ff];
   assign status.push   = push;
   assign status.pop    = pop;
   assign status.full   = (count_ff == 2'd2);
   assign status.empty  = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/caes_back.sv */
`default_nettype none
module caes_back
   import caes_pkg::*;
#(
   parameter int SAMPLE_BITS  = 16,
   parameter int ENTRY_W      = 2 * CARRIER_W + FIELDS * SAMPLE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cfg_type                   cfg,
   input  wire logic [ENTRY_W-1:0]        entry,
   input  wire queue_ctl_type             qstat,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_out_re,
   output logic signed [OUT_W-1:0]        rsp_out_im
);

   localparam int CH_W   = $clog2(NEG_CHANNELS + 1);
   localparam int PROD_W = SAMPLE_BITS + 17;
   localparam int ROT_W  = SAMPLE_BITS + 2;
   localparam int ACC_W  = SAMPLE_BITS + 5;
   localparam int SIDX_W = $clog2(FIELDS);

   typedef enum logic [3:0] {
      S_IDLE, S_PHASE, S_MULP, S_SX2, S_ST7, S_ST5, S_ST3, S_ST1, S_SY,
      S_ROT_RE, S_ROT_IM, S_ACC, S_FINISH
   } state_type;

   state_type                              state_ff;
   logic [ENTRY_W-1:0]                     entry_ff;
   logic [CH_W-1:0]                        ch_ff;
   logic [CARRIER_W-1:0]                   diff_ff;
   logic [CARRIER_W-1:0]                   p_ff;
   logic                                   cos_sel_ff;
   logic [30:0]                            x_ff, x2_ff, t_ff;
   logic signed [15:0]                     sin_ff, cos_ff;
   logic signed [ROT_W-1:0]                rot_re_ff, rot_im_ff;
   logic signed [ACC_W-1:0]                acc_re_ff, acc_im_ff;
   logic                                   rsp_valid_ff;
   logic signed [OUT_W-1:0]                out_re_ff, out_im_ff;

   logic [FIELDS-1:0][SAMPLE_BITS-1:0]     samp;
   logic [CARRIER_W-1:0]                   oc, tm;
   logic [4:0][CARRIER_W-1:0]              car;
   logic signed [SAMPLE_BITS-1:0]          a, b;
   logic [CARRIER_W-1:0]                   ph;
   logic [30:0]                            r, x_in;
   logic [31:0]                            mul_a, mul_b;
   logic [63:0]                            prod;
   logic [30:0]                            prod_sh;
   logic [30:0]                            coef;
   logic [16:0]                            s_mag;
   logic [15:0]                            s_sat;
   logic signed [15:0]                     s_val;
   logic signed [PROD_W-1:0]               p_re, p_im;
   logic signed [PROD_W-1:0]               r_re, r_im;
   logic                                   out_free;

   assign samp = entry_ff[FIELDS*SAMPLE_BITS-1:0];
   assign tm   = entry_ff[FIELDS*SAMPLE_BITS +: CARRIER_W];
   assign oc   = entry_ff[FIELDS*SAMPLE_BITS+CARRIER_W +: CARRIER_W];
   assign car  = {cfg.neg_carrier, cfg.pos_carrier};
   assign a    = $signed(samp[SIDX_W'(2 * ch_ff)]);
   assign b    = $signed(samp[SIDX_W'(2 * ch_ff + 1)]);

   // sine argument folding
   assign ph   = cos_sel_ff ? p_ff + QUARTER_TURN : p_ff;
   assign r    = {1'b0, ph[29:0]};
   assign x_in = ph[30] ? Q30_ONE - r : r;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      coef  = C1;
      unique case (state_ff)
         S_MULP: begin
            mul_a = diff_ff;
            mul_b = tm;
         end
         S_SX2: begin
            mul_a = 32'(x_in);
            mul_b = 32'(x_in);
         end
         S_ST7: begin
            mul_a = 32'(x2_ff);
            mul_b = 32'(C9);
            coef  = C7;
         end
         S_ST5: begin
            mul_a = 32'(x2_ff);
            mul_b = 32'(t_ff);
            coef  = C5;
         end
         S_ST3: begin
            mul_a = 32'(x2_ff);
            mul_b = 32'(t_ff);
            coef  = C3;
         end
         S_ST1: begin
            mul_a = 32'(x2_ff);
            mul_b = 32'(t_ff);
         end
         S_SY: begin
            mul_a = 32'(x_ff);
            mul_b = 32'(t_ff);
         end
         default: begin
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign prod_sh = prod[60:30];
   assign s_mag   = 17'((32'(prod_sh) + 32'd16384) >> 15);
   assign s_sat   = s_mag[16:15] != 2'b00 ? 16'h7FFF : s_mag[15:0];
   assign s_val   = ph[31] ? -$signed(s_sat) : $signed(s_sat);

   // rotation products
   assign p_re = PROD_W'(a) * PROD_W'(cos_ff) - PROD_W'(b) * PROD_W'(sin_ff);
   assign p_im = PROD_W'(a) * PROD_W'(sin_ff) + PROD_W'(b) * PROD_W'(cos_ff);
   assign r_re = (p_re + PROD_W'(16384)) >>> 15;
   assign r_im = (p_im + PROD_W'(16384)) >>> 15;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = (state_ff == S_IDLE) && !qstat.empty;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = out_re_ff;
   assign rsp_out_im = out_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         cos_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!qstat.empty) begin
                  entry_ff <= entry;
                  ch_ff    <= '0;
                  state_ff <= S_PHASE;
               end
            end
            S_PHASE: begin
               diff_ff  <= car[3'(ch_ff)] - oc;
               state_ff <= S_MULP;
            end
            S_MULP: begin
               if (diff_ff == '0) begin
                  rot_re_ff <= ROT_W'(a);
                  rot_im_ff <= ROT_W'(b);
                  state_ff  <= S_ACC;
               end else begin
                  p_ff       <= prod[31:0];
                  cos_sel_ff <= 1'b0;
                  state_ff   <= S_SX2;
               end
            end
            S_SX2: begin
               x_ff     <= x_in;
               x2_ff    <= prod_sh;
               state_ff <= S_ST7;
            end
            S_ST7: begin
               t_ff     <= coef - prod_sh;
               state_ff <= S_ST5;
            end
            S_ST5: begin
               t_ff     <= coef - prod_sh;
               state_ff <= S_ST3;
            end
            S_ST3: begin
               t_ff     <= coef - prod_sh;
               state_ff <= S_ST1;
            end
            S_ST1: begin
               t_ff     <= coef - prod_sh;
               state_ff <= S_SY;
            end
            S_SY: begin
               if (!cos_sel_ff) begin
                  sin_ff     <= s_val;
                  cos_sel_ff <= 1'b1;
                  state_ff   <= S_SX2;
               end else begin
                  cos_ff   <= s_val;
                  state_ff <= S_ROT_RE;
               end
            end
            S_ROT_RE: begin
               rot_re_ff <= ROT_W'(r_re);
               state_ff  <= S_ROT_IM;
            end
            S_ROT_IM: begin
               rot_im_ff <= ROT_W'(r_im);
               state_ff  <= S_ACC;
            end
            S_ACC: begin
               if (ch_ff == '0) begin
                  acc_re_ff <= ACC_W'(rot_re_ff);
                  acc_im_ff <= ACC_W'(rot_im_ff);
               end else begin
                  acc_re_ff <= acc_re_ff - ACC_W'(rot_re_ff);
                  acc_im_ff <= acc_im_ff - ACC_W'(rot_im_ff);
               end
               if (ch_ff == CH_W'(NEG_CHANNELS)) begin
                  state_ff <= S_FINISH;
               end else begin
                  ch_ff    <= ch_ff + 1'b1;
                  state_ff <= S_PHASE;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  out_re_ff    <= OUT_W'(acc_re_ff);
                  out_im_ff    <= OUT_W'(acc_im_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      ch_ff <= CH_W'(NEG_CHANNELS)) else $error("channel count out of range");
   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished item not presented");
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_PHASE && ch_ff == '0) else $error("pop without start");
`endif

endmodule
`default_nettype wire

/* test/carrier_aligned_envelope_subtractor_tb.sv */
`default_nettype none
module carrier_aligned_envelope_subtractor_tb;
   import caes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] pos_re;
      logic signed [15:0] pos_im;
      logic signed [15:0] neg_re_a;
      logic signed [15:0] neg_im_a;
      logic signed [15:0] neg_re_b;
      logic signed [15:0] neg_im_b;
      logic signed [15:0] neg_re_c;
      logic signed [15:0] neg_im_c;
      logic signed [15:0] neg_re_d;
      logic signed [15:0] neg_im_d;
   } sample_set_type;

   typedef struct packed {
      logic [OUT_W-1:0] out_re;
      logic [OUT_W-1:0] out_im;
   } envelope_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   sample_set_type        req_set;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [OUT_W-1:0] rsp_out_re;
   logic signed [OUT_W-1:0] rsp_out_im;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CARRIER_W-1:0]  csr_wdata;

   cfg_type       mixer_cfg;
   logic [31:0]   sample_count;
   envelope_type  envelope_q[$];
   int            mismatches;
   bit            quiet;
   int            stall_left;

   carrier_aligned_envelope_subtractor u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pos_re   (req_set.pos_re),
      .req_pos_im   (req_set.pos_im),
      .req_neg_re_a (req_set.neg_re_a),
      .req_neg_im_a (req_set.neg_im_a),
      .req_neg_re_b (req_set.neg_re_b),
      .req_neg_im_b (req_set.neg_im_b),
      .req_neg_re_c (req_set.neg_re_c),
      .req_neg_im_c (req_set.neg_im_c),
      .req_neg_re_d (req_set.neg_re_d),
      .req_neg_im_d (req_set.neg_im_d),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_re   (rsp_out_re),
      .rsp_out_im   (rsp_out_im),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // quarter-wave polynomial, Q30 in and out
   function automatic logic [63:0] quarter_wave(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t = 64'(C9);
      t = 64'(C7) - ((x2 * t) >> 30);
      t = 64'(C5) - ((x2 * t) >> 30);
      t = 64'(C3) - ((x2 * t) >> 30);
      t = 64'(C1) - ((x2 * t) >> 30);
      return (x * t) >> 30;
   endfunction

   function automatic longint sine_q15(input logic [31:0] p);
      logic [63:0] x;
      logic [63:0] s;
      x = p[30] ? (64'(Q30_ONE) - 64'(p[29:0])) : 64'(p[29:0]);
      s = (quarter_wave(x) + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      return p[31] ? -longint'(s) : longint'(s);
   endfunction

   task automatic rotate_sample(input longint a, input longint b, input logic [31:0] diff,
                                input logic [31:0] tm, output longint re, output longint im);
      logic [31:0] p;
      longint s;
      longint c;
      if (diff == 32'd0) begin
         re = a;
         im = b;
      end else begin
         p = diff * tm;
         s = sine_q15(p);
         c = sine_q15(p + QUARTER_TURN);
         re = (a * c - b * s + 16384) >>> 15;
         im = (a * s + b * c + 16384) >>> 15;
      end
   endtask

   task automatic predict_envelope(input sample_set_type st, output envelope_type env);
      longint carrier[4];
      longint lo;
      longint hi;
      longint total;
      longint sel;
      longint acc_re;
      longint acc_im;
      longint re;
      longint im;
      longint nre[4];
      longint nim[4];
      logic [31:0] out_carrier;
      logic [31:0] tm;
      nre = '{st.neg_re_a, st.neg_re_b, st.neg_re_c, st.neg_re_d};
      nim = '{st.neg_im_a, st.neg_im_b, st.neg_im_c, st.neg_im_d};
      for (int i = 0; i < 4; i++) carrier[i] = longint'(signed'(mixer_cfg.neg_carrier[i]));
      lo = carrier[0];
      hi = carrier[0];
      total = 0;
      for (int i = 0; i < 4; i++) begin
         if (carrier[i] < lo) lo = carrier[i];
         if (carrier[i] > hi) hi = carrier[i];
         total += carrier[i];
      end
      case (mixer_cfg.out_mode)
         MODE_MIN:  sel = lo;
         MODE_MAX:  sel = hi;
         MODE_MEAN: sel = total / 4;
         default:   sel = longint'(signed'(mixer_cfg.user_carrier));
      endcase
      out_carrier = sel[31:0];
      tm = sample_count + mixer_cfg.start_offset;
      rotate_sample(longint'(st.pos_re), longint'(st.pos_im),
                    mixer_cfg.pos_carrier - out_carrier, tm, acc_re, acc_im);
      for (int i = 0; i < 4; i++) begin
         rotate_sample(nre[i], nim[i], mixer_cfg.neg_carrier[i] - out_carrier, tm, re, im);
         acc_re -= re;
         acc_im -= im;
      end
      env.out_re = acc_re[OUT_W-1:0];
      env.out_im = acc_im[OUT_W-1:0];
      sample_count = sample_count + 32'd1;
   endtask

   task automatic report(input string what, input logic [OUT_W-1:0] got,
                         input logic [OUT_W-1:0] want);
      $display("mismatch %s: got %h expected %h at %t", what, got, want, $realtime);
      mismatches++;
   endtask

   // result check
   always @(posedge clock) begin
      envelope_type env;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (envelope_q.size() == 0) begin
            report("unexpected transfer", rsp_out_re, '0);
         end else begin
            env = envelope_q.pop_front();
            if (rsp_out_re !== env.out_re) report("out_re", rsp_out_re, env.out_re);
            if (rsp_out_im !== env.out_im) report("out_im", rsp_out_im, env.out_im);
         end
      end
   end

   // receiver stalls, counted over cycles with a result waiting
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = quiet ? 0 : $urandom_range(16, 0);
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (rsp_valid && stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // called just after a rising edge; returns after the accepting edge
   task automatic send_set(input sample_set_type st);
      envelope_type env;
      int gap;
      gap = quiet ? 0 : $urandom_range(16, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_set <= st;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      predict_envelope(st, env);
      envelope_q = {envelope_q, env};
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (envelope_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_POS_CARRIER:   mixer_cfg.pos_carrier = value;
         REG_NEG_CARRIER_A: mixer_cfg.neg_carrier[0] = value;
         REG_NEG_CARRIER_B: mixer_cfg.neg_carrier[1] = value;
         REG_NEG_CARRIER_C: mixer_cfg.neg_carrier[2] = value;
         REG_NEG_CARRIER_D: mixer_cfg.neg_carrier[3] = value;
         REG_OUT_MODE:      mixer_cfg.out_mode = value[1:0];
         REG_USER_CARRIER:  mixer_cfg.user_carrier = value;
         default:           mixer_cfg.start_offset = value;
      endcase
   endtask

   task automatic load_cfg(input logic [31:0] pos, input logic [31:0] na, input logic [31:0] nb,
                           input logic [31:0] nc, input logic [31:0] nd, input logic [1:0] mode,
                           input logic [31:0] user, input logic [31:0] offset);
      write_reg(REG_POS_CARRIER, pos);
      write_reg(REG_NEG_CARRIER_A, na);
      write_reg(REG_NEG_CARRIER_B, nb);
      write_reg(REG_NEG_CARRIER_C, nc);
      write_reg(REG_NEG_CARRIER_D, nd);
      write_reg(REG_OUT_MODE, {30'($urandom_range(1073741823, 0)), mode});
      write_reg(REG_USER_CARRIER, user);
      write_reg(REG_START_OFFSET, offset);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_field();
      case ($urandom_range(7, 0))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_set_type random_set();
      sample_set_type st;
      st = {pick_field(), pick_field(), pick_field(), pick_field(), pick_field(),
            pick_field(), pick_field(), pick_field(), pick_field(), pick_field()};
      return st;
   endfunction

   function automatic logic [31:0] pick_carrier(input logic [31:0] other);
      case ($urandom_range(6, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'd0;
         3:       return other;
         4:       return 32'(signed'($urandom_range(4000, 0)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_field_extremes();
      send_set({10{16'h8000}});
      send_set({10{16'h7fff}});
      send_set({10{16'h0000}});
      send_set({16'h7fff, 16'h7fff, {8{16'h8000}}});
      send_set({16'h8000, 16'h8000, {8{16'h7fff}}});
      send_set({5{16'h7fff, 16'h8000}});
      send_set({10{16'hffff}});
      wait_idle();
   endtask

   task automatic test_output_modes();
      load_cfg(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'hffff_ffff,
               MODE_MIN, 32'h0, 32'hffff_fffe);
      send_set({10{16'h8000}});
      send_set(random_set());
      send_set(random_set());
      wait_idle();
      write_reg(REG_OUT_MODE, 32'(MODE_MAX));
      csr_we <= 1'b0;
      send_set({10{16'h7fff}});
      send_set(random_set());
      wait_idle();
      write_reg(REG_OUT_MODE, 32'(MODE_MEAN));
      csr_we <= 1'b0;
      send_set(random_set());
      send_set({10{16'h8000}});
      wait_idle();
      // equal carriers: every channel passes straight through
      load_cfg(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
               MODE_USER, 32'h0100_0000, 32'hffff_ffff);
      send_set({10{16'h8000}});
      send_set(random_set());
      wait_idle();
      load_cfg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               MODE_USER, 32'h8000_0000, 32'h0);
      send_set({10{16'h7fff}});
      send_set({10{16'h8000}});
      send_set(random_set());
      wait_idle();
   endtask

   task automatic test_random_phases();
      logic [31:0] base;
      logic [31:0] offset;
      for (int phase = 0; phase < 17; phase++) begin
         quiet = ($urandom_range(3, 0) == 0);
         base = pick_carrier($urandom);
         offset = ($urandom_range(1, 0) != 0) ? $urandom : 32'($urandom_range(3, 0)) - 32'd2;
         load_cfg(pick_carrier(base), pick_carrier(base), pick_carrier(base),
                  pick_carrier(base), pick_carrier(base), 2'($urandom_range(3, 0)),
                  pick_carrier(base), offset);
         repeat (50) send_set(random_set());
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_set = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      quiet = 1'b0;
      sample_count = 32'd0;
      mixer_cfg = '0;
      mixer_cfg.out_mode = MODE_MEAN;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_output_modes();
      test_random_phases();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && envelope_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
